FILE: design/ccs_pkg.sv
// package for the c comment stripper: lexer modes, error codes, byte constants
// and the result record passed from the lexer to the output stage
// no dependencies
package ccs_pkg;

  // fixed field widths of the channels
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 2;
  localparam int unsigned NL_REPEAT_W = 10;
  localparam int unsigned ERR_LINE_W  = 20;

  // characters the lexer reacts to
  localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;

  // lexer modes
  typedef enum logic [3:0] {
    MODE_NORMAL       = 4'd0,
    MODE_SLASH        = 4'd1,
    MODE_LINE_CMT     = 4'd2,
    MODE_BLOCK_CMT    = 4'd3,
    MODE_BLOCK_STAR   = 4'd4,
    MODE_STR          = 4'd5,
    MODE_STR_ESC      = 4'd6,
    MODE_CHR          = 4'd7,
    MODE_CHR_ESC      = 4'd8,
    MODE_DONE_OK      = 4'd9,
    MODE_DONE_COMMENT = 4'd10,
    MODE_DONE_STR     = 4'd11,
    MODE_DONE_CHR     = 4'd12
  } mode_t;

  // error codes reported at end of stream
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPEN_CMT = 2'd1,
    ERR_OPEN_STR = 2'd2,
    ERR_OPEN_CHR = 2'd3
  } err_kind_t;

  // one result item
  typedef struct packed {
    logic [COUNT_W-1:0]     byte_count;
    logic [BYTE_W-1:0]      first_byte;
    logic [BYTE_W-1:0]      second_byte;
    logic [NL_REPEAT_W-1:0] newline_repeat;
    logic                   finished;
    err_kind_t              error_kind;
    logic [ERR_LINE_W-1:0]  error_line;
  } result_t;

endpackage

FILE: design/ccs_channels.sv
// valid/ready channel interfaces for the c comment stripper
// depends on ccs_pkg for the field widths

// source byte channel
interface ccs_in_if;
  import ccs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// result channel
interface ccs_out_if;
  import ccs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COUNT_W-1:0]     byte_count;
  logic [BYTE_W-1:0]      first_byte;
  logic [BYTE_W-1:0]      second_byte;
  logic [NL_REPEAT_W-1:0] newline_repeat;
  logic                   finished;
  logic [1:0]             error_kind;
  logic [ERR_LINE_W-1:0]  error_line;

  modport source (output valid, output byte_count, output first_byte, output second_byte,
                  output newline_repeat, output finished, output error_kind,
                  output error_line, input ready);
  modport sink   (input valid, input byte_count, input first_byte, input second_byte,
                  input newline_repeat, input finished, input error_kind,
                  input error_line, output ready);
endinterface

FILE: design/c_comment_stripper_core.sv
// c comment stripper, top level: input register, lexer step and result register
// depends on ccs_pkg, ccs_channels (ccs_in_if, ccs_out_if) and ccs_lexer
//
// usage:
//   in_if carries one source byte per item (in_byte), or an end mark
//   (end_of_stream = 1, byte ignored). out_if returns exactly one result item
//   per input item: up to two bytes (byte_count, first_byte, second_byte),
//   a count of newlines to emit after them (newline_repeat), and at end of
//   stream the finished flag with error_kind/error_line for an open comment,
//   string or char literal. Items after the end mark return the final status.
//   an accepted item sits in the input register, is stepped by the lexer
//   (combinational) and its result is loaded into the result register, from
//   which out_if presents it. throughput: one item per cycle while out_if does
//   not stall, set by the lexer step between the input and result registers.
//   when out_if stalls, the result register holds and the input register
//   takes one more item; in_if.ready then drops until out_if moves again.
//   reset (rst_n low, synchronous) empties both registers and puts the lexer
//   in normal text mode at line one.
module c_comment_stripper_core
  import ccs_pkg::*;
#(
  parameter int unsigned LINE_BITS    = 20,
  parameter int unsigned NEWLINE_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  ccs_in_if.sink           in_if,
  ccs_out_if.source        out_if
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eos_r;
  logic              out_valid_r;
  result_t           out_data_r;
  result_t           step_result;
  logic              advance;

  // item moves from input register to result register
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.in_byte;
      in_eos_r  <= in_if.end_of_stream;
    end
  end

  // lexer step
  ccs_lexer #(
    .LINE_BITS    (LINE_BITS),
    .NEWLINE_BITS (NEWLINE_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .cur_byte (in_byte_r),
    .cur_eos  (in_eos_r),
    .result   (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  // result channel
  assign out_if.valid          = out_valid_r;
  assign out_if.byte_count     = out_data_r.byte_count;
  assign out_if.first_byte     = out_data_r.first_byte;
  assign out_if.second_byte    = out_data_r.second_byte;
  assign out_if.newline_repeat = out_data_r.newline_repeat;
  assign out_if.finished       = out_data_r.finished;
  assign out_if.error_kind     = out_data_r.error_kind;
  assign out_if.error_line     = out_data_r.error_line;

endmodule

FILE: design/ccs_lexer.sv
// lexer state and one-step transition of the c comment stripper
// holds mode, line counter, open line and pending newline count; depends on ccs_pkg
module ccs_lexer
  import ccs_pkg::*;
#(
  parameter int unsigned LINE_BITS    = 20,
  parameter int unsigned NEWLINE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] cur_byte,
  input  logic              cur_eos,
  output result_t           result
);

  mode_t                   mode_r, mode_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [LINE_BITS-1:0]    open_r, open_nxt;
  logic [NEWLINE_BITS-1:0] pend_r, pend_nxt;

  // widened copies so the fixed-width outputs can be cut from them
  logic [31:0] open_wide;
  logic [15:0] pend_wide;

  assign open_wide = 32'(open_r);
  assign pend_wide = 16'(pend_r);

  // next state and result for the byte held in the input register
  always_comb begin
    logic                 normal_path;
    logic [LINE_BITS-1:0] line_cur;
    logic [BYTE_W-1:0]    c;
    mode_t                done_mode;
    logic                 do_finish;

    mode_nxt    = mode_r;
    line_nxt    = line_r;
    open_nxt    = open_r;
    pend_nxt    = pend_r;
    result      = '0;
    normal_path = 1'b0;
    do_finish   = 1'b0;
    done_mode   = MODE_DONE_OK;
    c           = cur_byte;
    line_cur    = line_r;

    if (mode_r inside {MODE_DONE_OK, MODE_DONE_COMMENT, MODE_DONE_STR, MODE_DONE_CHR}) begin
      // stream already over: repeat the final status
      do_finish = 1'b1;
      done_mode = mode_r;
    end else if (cur_eos) begin
      do_finish = 1'b1;
      case (mode_r)
        MODE_SLASH: begin
          result.first_byte = CH_SLASH;
          result.byte_count = COUNT_W'(1);
          done_mode         = MODE_DONE_OK;
        end
        MODE_LINE_CMT: begin
          result.first_byte = CH_SPACE;
          result.byte_count = COUNT_W'(1);
          done_mode         = MODE_DONE_OK;
        end
        MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
          result.first_byte     = CH_SPACE;
          result.byte_count     = COUNT_W'(1);
          result.newline_repeat = pend_wide[NL_REPEAT_W-1:0];
          pend_nxt              = '0;
          done_mode             = MODE_DONE_COMMENT;
        end
        MODE_STR, MODE_STR_ESC: done_mode = MODE_DONE_STR;
        MODE_CHR, MODE_CHR_ESC: done_mode = MODE_DONE_CHR;
        default:                done_mode = MODE_DONE_OK;
      endcase
    end else begin
      // saturating line count
      if (c == CH_NEWLINE && line_r != '1) begin
        line_cur = line_r + LINE_BITS'(1);
      end
      line_nxt = line_cur;

      case (mode_r)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_LINE_CMT;
          end else if (c == CH_STAR) begin
            open_nxt = line_cur;
            pend_nxt = '0;
            mode_nxt = MODE_BLOCK_CMT;
          end else begin
            // lone slash: emit it, then treat the byte as normal text
            result.first_byte = CH_SLASH;
            result.byte_count = COUNT_W'(1);
            normal_path       = 1'b1;
          end
        end
        MODE_LINE_CMT: begin
          if (c == CH_NEWLINE) begin
            result.first_byte  = CH_SPACE;
            result.second_byte = CH_NEWLINE;
            result.byte_count  = COUNT_W'(2);
            mode_nxt           = MODE_NORMAL;
          end
        end
        MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
          if (mode_r == MODE_BLOCK_STAR && c == CH_SLASH) begin
            result.first_byte     = CH_SPACE;
            result.byte_count     = COUNT_W'(1);
            result.newline_repeat = pend_wide[NL_REPEAT_W-1:0];
            pend_nxt              = '0;
            mode_nxt              = MODE_NORMAL;
          end else if (c == CH_STAR) begin
            mode_nxt = MODE_BLOCK_STAR;
          end else begin
            if (c == CH_NEWLINE && pend_r != '1) begin
              pend_nxt = pend_r + NEWLINE_BITS'(1);
            end
            mode_nxt = MODE_BLOCK_CMT;
          end
        end
        MODE_STR, MODE_CHR: begin
          result.first_byte = c;
          result.byte_count = COUNT_W'(1);
          if (c == CH_BACKSLASH) begin
            mode_nxt = (mode_r == MODE_STR) ? MODE_STR_ESC : MODE_CHR_ESC;
          end else if ((mode_r == MODE_STR && c == CH_DQUOTE) ||
                       (mode_r == MODE_CHR && c == CH_SQUOTE)) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_STR_ESC: begin
          result.first_byte = c;
          result.byte_count = COUNT_W'(1);
          mode_nxt          = MODE_STR;
        end
        MODE_CHR_ESC: begin
          result.first_byte = c;
          result.byte_count = COUNT_W'(1);
          mode_nxt          = MODE_CHR;
        end
        default: normal_path = 1'b1;
      endcase

      // normal text handling, possibly after an emitted slash
      if (normal_path) begin
        mode_nxt = MODE_NORMAL;
        if (c == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else begin
          if (c == CH_DQUOTE) begin
            open_nxt = line_cur;
            mode_nxt = MODE_STR;
          end else if (c == CH_SQUOTE) begin
            open_nxt = line_cur;
            mode_nxt = MODE_CHR;
          end
          if (result.byte_count == '0) begin
            result.first_byte = c;
          end else begin
            result.second_byte = c;
          end
          result.byte_count = result.byte_count + COUNT_W'(1);
        end
      end
    end

    // end of stream status
    if (do_finish) begin
      mode_nxt        = done_mode;
      result.finished = 1'b1;
      case (done_mode)
        MODE_DONE_COMMENT: result.error_kind = ERR_OPEN_CMT;
        MODE_DONE_STR:     result.error_kind = ERR_OPEN_STR;
        MODE_DONE_CHR:     result.error_kind = ERR_OPEN_CHR;
        default:           result.error_kind = ERR_NONE;
      endcase
      if (done_mode != MODE_DONE_OK) begin
        result.error_line = open_wide[ERR_LINE_W-1:0];
      end
    end
  end

  // state registers, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      line_r <= LINE_BITS'(1);
      open_r <= '0;
      pend_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      open_r <= open_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: verif/tb_c_comment_stripper_core.sv
// testbench for c_comment_stripper_core: C-like source bytes in, stripped bytes and status out
// depends on ccs_pkg, ccs_channels and the core; in-bench comment stripper predicts every result
module tb_c_comment_stripper_core;
  import ccs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_W      = ERR_LINE_W;
  localparam int unsigned NL_W        = NL_REPEAT_W;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 64;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eos;
  } src_item_t;

  logic clk = 1'b0;
  logic rst_n;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  c_comment_stripper_core #(
    .LINE_BITS    (LINE_W),
    .NEWLINE_BITS (NL_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #10 clk = ~clk;

  // source items waiting for the driver, predicted stripped output waiting for the monitor
  src_item_t   source_bytes[$];
  result_t     stripped_q[$];
  src_item_t   next_src;
  result_t     exp_r;

  // stripper state as predicted
  mode_t               lex_mode;
  logic [LINE_W-1:0]   line_no;
  logic [LINE_W-1:0]   open_ln;
  logic [NL_W-1:0]     nl_pending;
  err_kind_t           done_kind;

  // traffic control
  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          long_hold_req;
  bit          in_taken;

  // bookkeeping
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned n_marks;
  int unsigned n_checked;
  int unsigned n_fail;
  int unsigned n_cycles;
  int unsigned max_nl;

  // ---------------------------------------------------------------- predictor

  // append one byte to a result
  function automatic void put_out(inout result_t r, input logic [BYTE_W-1:0] b);
    if (r.byte_count == 2'd0) begin
      r.first_byte = b;
    end else begin
      r.second_byte = b;
    end
    r.byte_count = r.byte_count + 2'd1;
  endfunction

  // byte seen in plain text
  function automatic void plain_char(input logic [BYTE_W-1:0] b, inout result_t r);
    lex_mode = MODE_NORMAL;
    if (b == CH_SLASH) begin
      lex_mode = MODE_SLASH;
    end else begin
      if (b == CH_DQUOTE) begin
        open_ln  = line_no;
        lex_mode = MODE_STR;
      end else if (b == CH_SQUOTE) begin
        open_ln  = line_no;
        lex_mode = MODE_CHR;
      end
      put_out(r, b);
    end
  endfunction

  // stream closes with the given status
  function automatic void end_stream(input mode_t m, input err_kind_t k, inout result_t r);
    lex_mode     = m;
    done_kind    = k;
    r.finished   = 1'b1;
    r.error_kind = k;
    r.error_line = (k == ERR_NONE) ? '0 : open_ln;
  endfunction

  // one source item in, one result out
  function automatic result_t strip_step(input logic [BYTE_W-1:0] b, input logic eos);
    result_t r;
    r = '0;
    if (lex_mode >= MODE_DONE_OK) begin
      // already finished: repeat the final status
      r.finished   = 1'b1;
      r.error_kind = done_kind;
      r.error_line = (done_kind == ERR_NONE) ? '0 : open_ln;
    end else if (eos) begin
      case (lex_mode)
        MODE_SLASH: begin
          put_out(r, CH_SLASH);
          end_stream(MODE_DONE_OK, ERR_NONE, r);
        end
        MODE_LINE_CMT: begin
          put_out(r, CH_SPACE);
          end_stream(MODE_DONE_OK, ERR_NONE, r);
        end
        MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
          put_out(r, CH_SPACE);
          r.newline_repeat = nl_pending;
          nl_pending = '0;
          end_stream(MODE_DONE_COMMENT, ERR_OPEN_CMT, r);
        end
        MODE_STR, MODE_STR_ESC: end_stream(MODE_DONE_STR, ERR_OPEN_STR, r);
        MODE_CHR, MODE_CHR_ESC: end_stream(MODE_DONE_CHR, ERR_OPEN_CHR, r);
        default: end_stream(MODE_DONE_OK, ERR_NONE, r);
      endcase
    end else begin
      if (b == CH_NEWLINE && line_no != {LINE_W{1'b1}}) line_no = line_no + LINE_W'(1);
      case (lex_mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            lex_mode = MODE_LINE_CMT;
          end else if (b == CH_STAR) begin
            open_ln    = line_no;
            nl_pending = '0;
            lex_mode   = MODE_BLOCK_CMT;
          end else begin
            // lone slash: emit it and treat the byte as plain text
            put_out(r, CH_SLASH);
            plain_char(b, r);
          end
        end
        MODE_LINE_CMT: begin
          if (b == CH_NEWLINE) begin
            put_out(r, CH_SPACE);
            put_out(r, CH_NEWLINE);
            lex_mode = MODE_NORMAL;
          end
        end
        MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
          if (lex_mode == MODE_BLOCK_STAR && b == CH_SLASH) begin
            put_out(r, CH_SPACE);
            r.newline_repeat = nl_pending;
            nl_pending = '0;
            lex_mode = MODE_NORMAL;
          end else if (b == CH_STAR) begin
            lex_mode = MODE_BLOCK_STAR;
          end else begin
            if (b == CH_NEWLINE && nl_pending != {NL_W{1'b1}}) begin
              nl_pending = nl_pending + NL_W'(1);
            end
            lex_mode = MODE_BLOCK_CMT;
          end
        end
        MODE_STR, MODE_CHR: begin
          put_out(r, b);
          if (b == CH_BACKSLASH) begin
            if (lex_mode == MODE_STR) begin
              lex_mode = MODE_STR_ESC;
            end else begin
              lex_mode = MODE_CHR_ESC;
            end
          end else if ((lex_mode == MODE_STR && b == CH_DQUOTE) ||
                       (lex_mode == MODE_CHR && b == CH_SQUOTE)) begin
            lex_mode = MODE_NORMAL;
          end
        end
        MODE_STR_ESC: begin
          put_out(r, b);
          lex_mode = MODE_STR;
        end
        MODE_CHR_ESC: begin
          put_out(r, b);
          lex_mode = MODE_CHR;
        end
        default: plain_char(b, r);
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  // source side: one item offered until taken, random gaps between items
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.in_byte       <= '0;
      in_if.end_of_stream <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (source_bytes.size() > 0) begin
        next_src = source_bytes.pop_front();
        in_if.valid         <= 1'b1;
        in_if.in_byte       <= next_src.b;
        in_if.end_of_stream <= next_src.eos;
        if ($urandom_range(0, 99) < send_pct) send_gap = $urandom_range(1, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side: random stall bursts plus one long hold on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_pct) begin
      stall_left = $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // predict on every accepted item, compare every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        stripped_q.push_back(strip_step(in_if.in_byte, in_if.end_of_stream));
        in_taken = 1'b1;
        n_taken++;
        if (in_if.end_of_stream) n_marks++;
      end
      if (out_if.valid && out_if.ready) begin
        if (stripped_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          n_fail++;
        end else begin
          exp_r = stripped_q.pop_front();
          check_field("byte_count",     32'(exp_r.byte_count),     32'(out_if.byte_count));
          check_field("first_byte",     32'(exp_r.first_byte),     32'(out_if.first_byte));
          check_field("second_byte",    32'(exp_r.second_byte),    32'(out_if.second_byte));
          check_field("newline_repeat", 32'(exp_r.newline_repeat),
                      32'(out_if.newline_repeat));
          check_field("finished",       32'(exp_r.finished),       32'(out_if.finished));
          check_field("error_kind",     32'(exp_r.error_kind),     32'(out_if.error_kind));
          check_field("error_line",     32'(exp_r.error_line),     32'(out_if.error_line));
          if (32'(exp_r.newline_repeat) > max_nl) max_nl = 32'(exp_r.newline_repeat);
          n_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles, stripped_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // queue one source byte, keeping the queue short so traffic settings track time
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while (source_bytes.size() >= 16) @(posedge clk);
    source_bytes.push_back('{b: b, eos: 1'b0});
    n_queued++;
  endtask

  task automatic push_end();
    while (source_bytes.size() >= 16) @(posedge clk);
    source_bytes.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b1});
    n_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // ordinary code byte: nothing that opens a comment or literal
  function automatic logic [BYTE_W-1:0] plain_byte();
    string pool;
    pool = "azAZ_09 =+;(){}*,#\t";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // any byte except the closing quote and the backslash
  function automatic logic [BYTE_W-1:0] literal_byte(input logic [BYTE_W-1:0] quote);
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == quote || b == CH_BACKSLASH) b = 8'h61;
    return b;
  endfunction

  // one well-formed construct with random content, or a little noise
  task automatic add_token(input bit noisy);
    int unsigned pick;
    int unsigned n;
    logic [BYTE_W-1:0] b;
    pick = noisy ? $urandom_range(0, 99) : $urandom_range(0, 89);
    if (pick < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(plain_byte());
    end else if (pick < 40) begin
      push_byte(CH_NEWLINE);
    end else if (pick < 52) begin
      // string literal with escapes
      push_byte(CH_DQUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte(CH_BACKSLASH);
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(literal_byte(CH_DQUOTE));
        end
      end
      push_byte(CH_DQUOTE);
    end else if (pick < 60) begin
      // character literal
      push_byte(CH_SQUOTE);
      if ($urandom_range(0, 2) == 0) begin
        push_byte(CH_BACKSLASH);
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(literal_byte(CH_SQUOTE));
      end
      push_byte(CH_SQUOTE);
    end else if (pick < 70) begin
      // line comment
      push_byte(CH_SLASH);
      push_byte(CH_SLASH);
      n = $urandom_range(0, 8);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        push_byte((b == CH_NEWLINE) ? 8'h7A : b);
      end
      push_byte(CH_NEWLINE);
    end else if (pick < 82) begin
      // block comment with newlines and star runs
      push_byte(CH_SLASH);
      push_byte(CH_STAR);
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: push_byte(CH_STAR);
          1: push_byte(CH_NEWLINE);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end
      n = $urandom_range(1, 3);
      repeat (n) push_byte(CH_STAR);
      push_byte(CH_SLASH);
    end else if (pick < 90) begin
      // lone slash, sometimes followed by a literal
      push_byte(CH_SLASH);
      case ($urandom_range(0, 2))
        0: push_byte(plain_byte());
        1: push_text("\"x\"");
        default: push_text("'y'");
      endcase
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic pick_traffic();
    case ($urandom_range(0, 2))
      0: send_pct = 0;
      1: send_pct = 20;
      default: send_pct = 50;
    endcase
    case ($urandom_range(0, 2))
      0: recv_pct = 0;
      1: recv_pct = 20;
      default: recv_pct = 50;
    endcase
  endtask

  task automatic random_run(input int unsigned n_items, input bit noisy);
    int unsigned stop_at;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      if (noisy && $urandom_range(0, 7) == 0) pick_traffic();
      add_token(noisy);
    end
  endtask

  // wait until every queued item is taken and every result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (source_bytes.size() != 0 || in_if.valid || stripped_q.size() != 0);
  endtask

  // close whatever construct is open so the next bytes start in plain text
  task automatic back_to_text();
    case (lex_mode)
      MODE_SLASH:      push_byte(CH_SPACE);
      MODE_LINE_CMT:   push_byte(CH_NEWLINE);
      MODE_BLOCK_CMT:  push_text("*/");
      MODE_BLOCK_STAR: push_byte(CH_SLASH);
      MODE_STR:        push_byte(CH_DQUOTE);
      MODE_STR_ESC:    push_text("x\"");
      MODE_CHR:        push_byte(CH_SQUOTE);
      MODE_CHR_ESC:    push_text("x'");
      default: ;
    endcase
  endtask

  initial begin
    int unsigned end_kind;
    rst_n      = 1'b0;
    lex_mode   = MODE_NORMAL;
    line_no    = LINE_W'(1);
    open_ln    = '0;
    nl_pending = '0;
    done_kind  = ERR_NONE;
    send_pct   = 20;
    recv_pct   = 20;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, escaped quote in a string, line comment,
    // block comment closed by a star run, escaped char, lone slash cases
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\n/\"x\\\"\"//x\n/*\n**/'\\''/a");

    random_run(150, 1'b1);

    // sender pause, then a long receiver hold while items keep coming
    wait_idle();
    long_hold_req = 1'b1;
    random_run(40, 1'b1);

    // block comment holding many newlines
    wait_idle();
    back_to_text();
    push_text("/*");
    for (int i = 0; i < 40; i++) begin
      push_byte(CH_NEWLINE);
      if (i % 10 == 0) push_byte(8'h78);
    end
    push_text("**/");

    random_run(150, 1'b1);

    // tail with no idling on either side
    send_pct = 0;
    recv_pct = 0;
    random_run(50, 1'b0);
    wait_idle();
    back_to_text();

    // end of stream from a randomly chosen construct
    end_kind = $urandom_range(0, 8);
    case (end_kind)
      1: push_text("/");
      2: push_text("//a");
      3: push_text("/*\n");
      4: push_text("/*\n*");
      5: push_text("\"ab");
      6: push_text("\"a\\");
      7: push_text("'a");
      8: push_text("'\\");
      default: ;
    endcase
    push_end();

    // items after the end mark only repeat the final status
    push_byte(8'($urandom_range(0, 255)));
    push_end();
    push_byte(8'($urandom_range(0, 255)));

    wait_idle();
    repeat (10) @(posedge clk);
    if (stripped_q.size() != 0) begin
      $error("%0d expected results never arrived", stripped_q.size());
      n_fail++;
    end

    $display("summary: %0d source items (%0d end marks) driven, %0d results compared",
             n_taken, n_marks, n_checked);
    $display("summary: stream closed in %s at line %0d, largest newline repeat %0d",
             lex_mode.name(), line_no, max_nl);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
